[rtl/rbt_pkg.sv]
// shared constants and modular helper for the red-black tree counter
package rbt_pkg;

    localparam int NODE_COUNT_W = 10;
    localparam int TREE_COUNT_W = 30;

    localparam logic [TREE_COUNT_W-1:0] MODULUS = 30'd1000000007;

    // sum of two residues, reduced once
    function automatic logic [TREE_COUNT_W-1:0] mod_add(
        input logic [TREE_COUNT_W-1:0] a,
        input logic [TREE_COUNT_W-1:0] b
    );
        logic [TREE_COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[TREE_COUNT_W-1:0];
    endfunction

endpackage

[rtl/rbt_ram.sv]
// table memory: one write port, two registered read ports
module rbt_ram #(
    parameter int DEPTH = 11264,
    parameter int AW    = 14
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [AW-1:0]                       waddr,
    input  logic [rbt_pkg::TREE_COUNT_W-1:0]    wdata,
    input  logic [AW-1:0]                       raddr0,
    input  logic [AW-1:0]                       raddr1,
    output logic [rbt_pkg::TREE_COUNT_W-1:0]    rdata0,
    output logic [rbt_pkg::TREE_COUNT_W-1:0]    rdata1
);

    logic [rbt_pkg::TREE_COUNT_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read ports
    always_ff @(posedge aclk) begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

[rtl/rbt_modred.sv]
// pipelined Barrett reduction of a product of two residues modulo the prime
module rbt_modred (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  logic [2*rbt_pkg::TREE_COUNT_W-1:0]  value,
    output logic                                out_valid,
    output logic [rbt_pkg::TREE_COUNT_W-1:0]    result
);

    localparam int TW = rbt_pkg::TREE_COUNT_W;
    localparam int QW = 2 * TW + 2;

    // floor(2^60 / modulus)
    localparam logic [TW:0] MU = 31'd1152921496;

    logic [3:0]     v_reg;
    logic [QW-1:0]  q_reg;
    logic [31:0]    xa_reg;
    logic [31:0]    xb_reg;
    logic [31:0]    t_reg;
    logic [31:0]    r_reg;
    logic [TW-1:0]  res_reg;
    logic [31:0]    r1;
    logic [31:0]    r2;

    // final remainder lies below three times the modulus, two trial subtractions
    always_comb begin
        r1 = r_reg;
        if (r1 >= {2'b00, rbt_pkg::MODULUS}) begin
            r1 = r1 - {2'b00, rbt_pkg::MODULUS};
        end
        r2 = r1;
        if (r2 >= {2'b00, rbt_pkg::MODULUS}) begin
            r2 = r2 - {2'b00, rbt_pkg::MODULUS};
        end
    end

    // valid shift register, one bit per stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // quotient estimate, quotient times modulus, difference, correction
    always_ff @(posedge aclk) begin
        q_reg   <= QW'(value[2*TW-1:TW-1]) * QW'(MU);
        xa_reg  <= value[31:0];
        t_reg   <= {1'b0, q_reg[QW-1:TW+1]} * {2'b00, rbt_pkg::MODULUS};
        xb_reg  <= xa_reg;
        r_reg   <= xb_reg - t_reg;
        res_reg <= r2[TW-1:0];
    end

    assign out_valid = v_reg[3];
    assign result    = res_reg;

endmodule

[rtl/red_black_tree_count_mod.sv]
// red-black tree counter top level: sequencer, multiply-accumulate pipeline, tables
// one request at a time; for every table entry it fills, an item issues its splits into
// the single multiply-accumulate pipeline, fed by the two read ports of each table
// memory, one split per cycle, and lets the pipeline drain before each table write;
// the final sum then reads one table entry per black height
// reset (aresetn low, synchronous) returns to idle and empties the output register
module red_black_tree_count_mod #(
    parameter int MAX_NODES        = 1023,
    parameter int MAX_BLACK_HEIGHT = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] node_count, [15:10] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [29:0] tree_count, [31:30] zero
);

    localparam int TW    = rbt_pkg::TREE_COUNT_W;
    localparam int MW    = $clog2(MAX_NODES + 1);
    localparam int NW    = (MW > rbt_pkg::NODE_COUNT_W) ? MW : rbt_pkg::NODE_COUNT_W;
    localparam int HW    = $clog2(MAX_BLACK_HEIGHT + 1);
    localparam int AW    = HW + MW;
    localparam int DEPTH = (MAX_BLACK_HEIGHT + 1) * (2 ** MW);

    typedef enum logic [3:0] {
        ST_IDLE, ST_BASE, ST_HSTART, ST_STEP, ST_DRAIN, ST_WRITE,
        ST_SUM_RD, ST_SUM_ADD, ST_DONE
    } state_t;

    state_t          state_reg;
    logic [NW-1:0]   n_reg;
    logic [HW-1:0]   maxh_reg;
    logic [HW-1:0]   h_reg;
    logic [NW-1:0]   j_reg;
    logic [NW-1:0]   jend_reg;
    logic [NW-1:0]   k_reg;
    logic            black_reg;
    logic [2:0]      cnt_reg;
    logic [TW-1:0]   sum_reg;
    logic            m_valid_reg;
    logic [TW-1:0]   m_data_reg;

    // entry m of height hh was filled this request when 2^hh - 1 <= m < 4^hh
    function automatic logic in_band(input logic [NW-1:0] x, input logic [HW-1:0] hh);
        logic [NW:0] x1;
        x1 = {1'b0, x} + (NW+1)'(1);
        return ((x1 >> hh) != '0) && ((x >> {hh, 1'b0}) == '0);
    endfunction

    function automatic logic above_low(input logic [NW-1:0] x, input logic [HW-1:0] hh);
        logic [NW:0] x1;
        x1 = {1'b0, x} + (NW+1)'(1);
        return (x1 >> hh) != '0;
    endfunction

    // request decode
    logic [NW-1:0] n_in;
    logic [NW:0]   n_in1;
    logic [HW-1:0] maxh_in;
    logic          n_out_of_range;

    always_comb begin
        n_in  = NW'(s_axis_tdata[rbt_pkg::NODE_COUNT_W-1:0]);
        n_in1 = {1'b0, n_in} + (NW+1)'(1);
        maxh_in = '0;
        for (int i = 1; i <= MAX_BLACK_HEIGHT; i++) begin
            if ((n_in1 >> i) != '0) begin
                maxh_in = HW'(i);
            end
        end
        n_out_of_range = (n_in == '0) || (n_in > NW'(MAX_NODES));
    end

    // bounds of the current height
    logic [NW-1:0] lo_h;
    logic [NW-1:0] jend_h;

    always_comb begin
        lo_h = (NW'(1) << h_reg) - NW'(1);
        if (int'({h_reg, 1'b0}) >= NW) begin
            jend_h = n_reg;
        end else begin
            jend_h = (NW'(1) << {h_reg, 1'b0}) - NW'(1);
            if (jend_h > n_reg) begin
                jend_h = n_reg;
            end
        end
    end

    // split addresses for the step being issued
    logic [HW-1:0] hm1;
    logic [NW-1:0] xa;
    logic [NW-1:0] xb;
    logic          issue;

    assign hm1   = h_reg - HW'(1);
    assign xa    = j_reg - NW'(1) - k_reg;
    assign xb    = k_reg;
    assign issue = (state_reg == ST_STEP);

    // reducer and table ports
    logic          red_valid;
    logic [TW-1:0] red_result;
    logic [TW-1:0] acc_reg;

    logic          blk_we, rr_we;
    logic [AW-1:0] blk_waddr, blk_raddr0, blk_raddr1, rr_addr0, rr_addr1, wr_addr;
    logic [TW-1:0] blk_wdata;
    logic [TW-1:0] blk_rd0, blk_rd1, rr_rd0, rr_rd1;

    assign wr_addr = {h_reg, j_reg[MW-1:0]};

    always_comb begin
        blk_we    = 1'b0;
        blk_waddr = wr_addr;
        blk_wdata = acc_reg;
        if (state_reg == ST_BASE) begin
            blk_we    = 1'b1;
            blk_waddr = {HW'(1), MW'(cnt_reg)};
            blk_wdata = (cnt_reg == 3'd2) ? TW'(2) : TW'(1);
        end else if (state_reg == ST_WRITE && black_reg) begin
            blk_we = 1'b1;
        end
        rr_we = (state_reg == ST_WRITE) && !black_reg;
        if (state_reg == ST_SUM_RD) begin
            blk_raddr0 = {h_reg, n_reg[MW-1:0]};
        end else begin
            blk_raddr0 = {hm1, xa[MW-1:0]};
        end
        blk_raddr1 = {hm1, xb[MW-1:0]};
        rr_addr0   = {h_reg, xa[MW-1:0]};
        rr_addr1   = {h_reg, xb[MW-1:0]};
    end

    rbt_ram #(.DEPTH(DEPTH), .AW(AW)) u_black_ram (
        .aclk   (aclk),
        .we     (blk_we),
        .waddr  (blk_waddr),
        .wdata  (blk_wdata),
        .raddr0 (blk_raddr0),
        .raddr1 (blk_raddr1),
        .rdata0 (blk_rd0),
        .rdata1 (blk_rd1)
    );

    rbt_ram #(.DEPTH(DEPTH), .AW(AW)) u_red_ram (
        .aclk   (aclk),
        .we     (rr_we),
        .waddr  (wr_addr),
        .wdata  (acc_reg),
        .raddr0 (rr_addr0),
        .raddr1 (rr_addr1),
        .rdata0 (rr_rd0),
        .rdata1 (rr_rd1)
    );

    // multiply-accumulate pipeline: issue, operands, product, reduction, accumulate
    logic            p1_v_reg, p2_v_reg, p3_v_reg;
    logic            p1_black_reg;
    logic            p1_mba_reg, p1_mbb_reg, p1_mra_reg, p1_mrb_reg;
    logic [TW-1:0]   oa_reg, ob_reg;
    logic [2*TW-1:0] prod_reg;
    logic [TW-1:0]   ba, bb, ra, rb;
    logic            acc_clr;

    assign acc_clr = (state_reg == ST_HSTART) || (state_reg == ST_WRITE);

    rbt_modred u_modred (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p3_v_reg),
        .value     (prod_reg),
        .out_valid (red_valid),
        .result    (red_result)
    );

    always_comb begin
        ba = p1_mba_reg ? blk_rd0 : '0;
        bb = p1_mbb_reg ? blk_rd1 : '0;
        ra = p1_mra_reg ? rr_rd0  : '0;
        rb = p1_mrb_reg ? rr_rd1  : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            acc_reg  <= '0;
        end else begin
            p1_v_reg <= issue;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            if (acc_clr) begin
                acc_reg <= '0;
            end else if (red_valid) begin
                acc_reg <= rbt_pkg::mod_add(acc_reg, red_result);
            end
        end
        p1_black_reg <= black_reg;
        p1_mba_reg   <= in_band(xa, hm1);
        p1_mbb_reg   <= in_band(xb, hm1);
        p1_mra_reg   <= above_low(xa, h_reg);
        p1_mrb_reg   <= above_low(xb, h_reg);
        oa_reg   <= p1_black_reg ? rbt_pkg::mod_add(ba, ra) : ba;
        ob_reg   <= p1_black_reg ? rbt_pkg::mod_add(bb, rb) : bb;
        prod_reg <= oa_reg * ob_reg;
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            black_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_axis_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        n_reg    <= n_in;
                        maxh_reg <= maxh_in;
                        sum_reg  <= '0;
                        cnt_reg  <= 3'd1;
                        state_reg <= n_out_of_range ? ST_DONE : ST_BASE;
                    end
                end
                ST_BASE: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd3) begin
                        if (maxh_reg == HW'(1)) begin
                            h_reg     <= HW'(1);
                            state_reg <= ST_SUM_RD;
                        end else begin
                            h_reg     <= HW'(2);
                            state_reg <= ST_HSTART;
                        end
                    end
                end
                ST_HSTART: begin
                    j_reg     <= lo_h;
                    jend_reg  <= jend_h;
                    k_reg     <= NW'(1);
                    black_reg <= 1'b0;
                    state_reg <= ST_STEP;
                end
                ST_STEP: begin
                    // last split issued: wait for it to reach the accumulator
                    if (k_reg == j_reg - NW'(2)) begin
                        cnt_reg   <= 3'd6;
                        state_reg <= ST_DRAIN;
                    end else begin
                        k_reg <= k_reg + NW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (cnt_reg == 3'd0) begin
                        state_reg <= ST_WRITE;
                    end else begin
                        cnt_reg <= cnt_reg - 3'd1;
                    end
                end
                ST_WRITE: begin
                    k_reg <= NW'(1);
                    if (!black_reg) begin
                        black_reg <= 1'b1;
                        state_reg <= ST_STEP;
                    end else if (j_reg == jend_reg) begin
                        if (h_reg == maxh_reg) begin
                            h_reg     <= HW'(1);
                            state_reg <= ST_SUM_RD;
                        end else begin
                            h_reg     <= h_reg + HW'(1);
                            state_reg <= ST_HSTART;
                        end
                    end else begin
                        j_reg     <= j_reg + NW'(1);
                        black_reg <= 1'b0;
                        state_reg <= ST_STEP;
                    end
                end
                ST_SUM_RD: begin
                    state_reg <= ST_SUM_ADD;
                end
                ST_SUM_ADD: begin
                    sum_reg <= rbt_pkg::mod_add(sum_reg,
                                                in_band(n_reg, h_reg) ? blk_rd0 : '0);
                    if (h_reg == maxh_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        h_reg     <= h_reg + HW'(1);
                        state_reg <= ST_SUM_RD;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_data_reg  <= sum_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_data_reg};

`ifndef SYNTHESIS
    // accumulator always holds a reduced residue
    assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg < rbt_pkg::MODULUS)
        else $error("accumulator not reduced");

    // no table write while splits are being issued
    assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> !blk_we && !rr_we)
        else $error("table write during multiply-accumulate issue");

    // delivered count is a reduced residue
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg < rbt_pkg::MODULUS)
        else $error("result not reduced");

    // pipeline is empty when the sum is written to a table
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WRITE |-> !p1_v_reg && !p2_v_reg && !p3_v_reg && !red_valid)
        else $error("table entry written with products in flight");
`endif

endmodule

[verif/red_black_tree_count_mod_test.sv]
// testbench for the red-black tree counter: directed, random, backpressure and no-idle tests
`timescale 1ns / 100ps

module red_black_tree_count_mod_test;

    localparam int  MAX_N      = 1023;
    localparam int  MAX_H      = 10;
    localparam longint PRIME   = 1000000007;
    localparam longint LIMIT   = 64'd60000000;
    localparam int  HOLD_LEN   = 300;
    localparam int  TAIL_WAIT  = 200;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [9:0] node_count, [15:10] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [29:0] tree_count, [31:30] zero

    logic [rbt_pkg::TREE_COUNT_W-1:0] tree_counts_due[$];
    logic [rbt_pkg::TREE_COUNT_W-1:0] count_memo[int];
    longint unsigned black_cnt[0:MAX_H][0:MAX_N];
    longint unsigned red_cnt[0:MAX_H][0:MAX_N];

    int     n_errors;
    int     n_sent;
    int     n_checked;
    int     max_sent;
    longint cycle_cnt;
    bit     idle_on;
    bit     hold_req;
    bit     hold_taken;
    int     hold_left;
    int     rx_idle;

    red_black_tree_count_mod i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // number of red-black trees with n internal nodes, by height and size tables
    function automatic logic [rbt_pkg::TREE_COUNT_W-1:0] count_trees(input int n);
        int top_h;
        longint unsigned lo_j;
        longint unsigned hi_j;
        longint unsigned acc;
        longint unsigned a;
        longint unsigned b;
        longint unsigned total;
        if (n == 0 || n > MAX_N) begin
            return '0;
        end
        if (count_memo.exists(n)) begin
            return count_memo[n];
        end
        top_h = 0;
        while (((n + 1) >> (top_h + 1)) != 0) begin
            top_h++;
        end
        if (top_h > MAX_H) begin
            top_h = MAX_H;
        end
        for (int h = 0; h <= top_h; h++) begin
            for (int m = 0; m <= n; m++) begin
                black_cnt[h][m] = 0;
                red_cnt[h][m]   = 0;
            end
        end
        // height one base entries, none beyond n
        if (top_h >= 1) begin
            black_cnt[1][1] = 1;
            red_cnt[1][1]   = 1;
            if (n >= 2) black_cnt[1][2] = 2;
            if (n >= 3) black_cnt[1][3] = 1;
        end
        for (int h = 2; h <= top_h; h++) begin
            lo_j = (64'd1 << h) - 1;
            hi_j = (64'd1 << (2 * h)) - 1;
            if (hi_j > n) hi_j = n;
            for (int j = int'(lo_j); j <= int'(hi_j); j++) begin
                acc = 0;
                for (int k = 1; k + 1 < j; k++) begin
                    acc = (acc + black_cnt[h-1][j-k-1] * black_cnt[h-1][k]) % PRIME;
                end
                red_cnt[h][j] = acc;
                acc = 0;
                for (int k = 1; k + 1 < j; k++) begin
                    a   = (black_cnt[h-1][j-k-1] + red_cnt[h][j-k-1]) % PRIME;
                    b   = (black_cnt[h-1][k] + red_cnt[h][k]) % PRIME;
                    acc = (acc + a * b) % PRIME;
                end
                black_cnt[h][j] = acc;
            end
        end
        total = 0;
        for (int h = 1; h <= top_h; h++) begin
            total = (total + black_cnt[h][n]) % PRIME;
        end
        count_memo[n] = total[rbt_pkg::TREE_COUNT_W-1:0];
        return total[rbt_pkg::TREE_COUNT_W-1:0];
    endfunction

    // offer one node count; valid stays high unless an idle burst precedes it
    task automatic send_count(input int n);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, n[rbt_pkg::NODE_COUNT_W-1:0]};
        do @(posedge aclk); while (!s_axis_tready);
        tree_counts_due.push_back(count_trees(n));
        n_sent++;
        if (n > max_sent) max_sent = n;
        @(negedge aclk);
    endtask

    // random node count, mostly small so the run stays short
    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 3);
            1, 2:    return $urandom_range(64, 127);
            default: return $urandom_range(4, 63);
        endcase
    endfunction

    task automatic test_directed_counts();
        int dir_counts[$];
        dir_counts = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 14, 15, 16, 31, 32, 63, 1023};
        foreach (dir_counts[i]) send_count(dir_counts[i]);
    endtask

    task automatic test_random_counts(input int n_items);
        repeat (n_items) send_count(pick_count());
    endtask

    // receiver holds off while counts keep coming, so the input stalls
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        repeat (8) send_count($urandom_range(0, 12));
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        repeat (15) send_count(pick_count());
    endtask

    // receiver ready: random idle bursts and one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        rx_idle       = 0;
        hold_taken    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_idle > 0) begin
                rx_idle--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                rx_idle = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // check each result transfer against the oldest expected count
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (tree_counts_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, m_axis_tdata);
                n_errors++;
            end else begin
                if (m_axis_tdata !== {2'b00, tree_counts_due[0]}) begin
                    $display("%0t: tree_count mismatch, expected %0d, actual %0d",
                             $time, tree_counts_due[0], m_axis_tdata);
                    n_errors++;
                end
                void'(tree_counts_due.pop_front());
                n_checked++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // test sequence
    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        n_errors      = 0;
        n_sent        = 0;
        n_checked     = 0;
        max_sent      = 0;
        cycle_cnt     = 0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_counts();
        test_random_counts(50);
        test_output_backpressure();
        test_random_counts(30);
        test_no_idle();

        s_axis_tvalid <= 1'b0;
        while (tree_counts_due.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("%0d node counts sent (largest %0d), %0d tree counts checked,",
                 n_sent, max_sent, n_checked);
        $display("with idle bursts on both sides and one long output hold-off");
        if (n_errors == 0 && tree_counts_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
